// ===== hw/rtl/sha_pkg.sv =====
// Shared types, round constants and SHA-256 mixing functions.
package sha_pkg;

	typedef struct packed {
		logic       cmd;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	typedef struct packed {
		logic        msg_end;
		logic [31:0] word;
	} q_word_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic CMD_ABSORB = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	localparam logic [0:7][31:0] H_INIT = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [0:63][31:0] K_TAB = {
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	function automatic logic [31:0] big_sig0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sig1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sig0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sig1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

// ===== hw/rtl/sha_queue.sv =====
// Four-entry word queue between the byte packer and the compression engine.
module sha_queue import sha_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  q_word_t push_word,
	input  logic    pop,
	output q_word_t pop_word,
	output q_stat_t stat
);

	q_word_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign stat.full  = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign stat.empty = (cnt_q == '0);
	assign pop_word   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/sha_front.sv =====
// Byte packer and padding sequencer: turns absorb and finish items into block words.
module sha_front import sha_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_data,
	output logic     push,
	output q_word_t  push_word,
	input  q_stat_t  q_stat
);

	localparam logic F_IDLE = 1'b0;
	localparam logic F_PAD  = 1'b1;

	logic        state_q;
	logic [23:0] acc_q;
	logic [5:0]  fill_q;
	logic [60:0] msg_q;
	logic [63:0] bits_q;
	logic [3:0]  widx_q;
	logic        first_q;
	logic        lenblk_q;

	logic        accept;
	logic [31:0] mark_word;
	logic [31:0] pad_word;
	logic        pad_end;

	assign in_ready = (state_q == F_IDLE) && !q_stat.full;
	assign accept   = in_valid && in_ready;
	assign pad_end  = lenblk_q && (widx_q == 4'd15);

	always_comb begin
		unique case (fill_q[1:0])
			2'd0: mark_word = 32'h8000_0000;
			2'd1: mark_word = {acc_q[7:0], 8'h80, 16'h0000};
			2'd2: mark_word = {acc_q[15:0], 8'h80, 8'h00};
			2'd3: mark_word = {acc_q[23:0], 8'h80};
			default: mark_word = 32'h8000_0000;
		endcase
		priority if (first_q) begin
			pad_word = mark_word;
		end else if (lenblk_q && widx_q == 4'd14) begin
			pad_word = bits_q[63:32];
		end else if (lenblk_q && widx_q == 4'd15) begin
			pad_word = bits_q[31:0];
		end else begin
			pad_word = '0;
		end
		if (state_q == F_PAD) begin
			push      = !q_stat.full;
			push_word = '{msg_end: pad_end, word: pad_word};
		end else begin
			push      = accept && (in_data.cmd == CMD_ABSORB) && (fill_q[1:0] == 2'd3);
			push_word = '{msg_end: 1'b0, word: {acc_q, in_data.data_byte}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IDLE;
			acc_q    <= '0;
			fill_q   <= '0;
			msg_q    <= '0;
			bits_q   <= '0;
			widx_q   <= '0;
			first_q  <= 1'b0;
			lenblk_q <= 1'b0;
		end else if (state_q == F_IDLE) begin
			if (accept && in_data.cmd == CMD_ABSORB) begin
				acc_q  <= {acc_q[15:0], in_data.data_byte};
				fill_q <= fill_q + 1'b1;
				msg_q  <= msg_q + 1'b1;
			end else if (accept) begin
				bits_q   <= {msg_q, 3'b000};
				widx_q   <= fill_q[5:2];
				first_q  <= 1'b1;
				lenblk_q <= (fill_q < 6'd56);
				state_q  <= F_PAD;
			end
		end else if (push) begin
			first_q <= 1'b0;
			widx_q  <= widx_q + 1'b1;
			if (widx_q == 4'd15) begin
				if (lenblk_q) begin
					fill_q  <= '0;
					msg_q   <= '0;
					state_q <= F_IDLE;
				end else begin
					lenblk_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== hw/rtl/sha_back.sv =====
// Compression engine: one round per cycle if fed, rolling schedule, digest register.
module sha_back import sha_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  q_word_t   q_word,
	input  q_stat_t   q_stat,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam logic [1:0] B_LOAD = 2'd0;
	localparam logic [1:0] B_EXP  = 2'd1;
	localparam logic [1:0] B_ADD  = 2'd2;
	localparam logic [1:0] B_OUT  = 2'd3;

	logic [1:0]  state_q;
	logic [5:0]  rnd_q;
	logic [2:0]  oidx_q;
	logic        last_q;
	logic [31:0] hash_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic        out_valid_q;
	out_item_t   out_q;

	logic [31:0] vin [8];
	logic [31:0] w_new;
	logic [31:0] wt;
	logic [31:0] t1;
	logic [31:0] t2;
	logic        step;
	logic        load_out;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign pop       = (state_q == B_LOAD) && !q_stat.empty;
	assign step      = pop || (state_q == B_EXP);
	assign load_out  = (state_q == B_OUT) && (!out_valid_q || out_ready);

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			vin[i] = (rnd_q == '0) ? hash_q[i] : v_q[i];
		end
		w_new = small_sig1(w_q[14]) + w_q[9] + small_sig0(w_q[1]) + w_q[0];
		wt    = (state_q == B_LOAD) ? q_word.word : w_new;
		t1    = vin[7] + big_sig1(vin[4]) + ((vin[4] & vin[5]) ^ (~vin[4] & vin[6]))
			+ K_TAB[rnd_q] + wt;
		t2    = big_sig0(vin[0]) + ((vin[0] & vin[1]) ^ (vin[0] & vin[2]) ^ (vin[1] & vin[2]));
	end

	always_ff @(posedge clk) begin
		if (step) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= wt;
			v_q[0]  <= t1 + t2;
			v_q[1]  <= vin[0];
			v_q[2]  <= vin[1];
			v_q[3]  <= vin[2];
			v_q[4]  <= vin[3] + t1;
			v_q[5]  <= vin[4];
			v_q[6]  <= vin[5];
			v_q[7]  <= vin[6];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_LOAD;
			rnd_q       <= '0;
			oidx_q      <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= H_INIT[i];
			end
		end else begin
			if (out_ready && !load_out) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_LOAD: begin
					if (pop) begin
						rnd_q <= rnd_q + 1'b1;
						if (rnd_q == 6'd15) begin
							last_q  <= q_word.msg_end;
							state_q <= B_EXP;
						end
					end
				end
				B_EXP: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == 6'd63) begin
						state_q <= B_ADD;
					end
				end
				B_ADD: begin
					for (int i = 0; i < 8; i++) begin
						hash_q[i] <= hash_q[i] + v_q[i];
					end
					oidx_q  <= '0;
					state_q <= last_q ? B_OUT : B_LOAD;
				end
				B_OUT: begin
					if (load_out) begin
						out_valid_q <= 1'b1;
						out_q       <= '{digest_word: hash_q[oidx_q], word_index: oidx_q,
							last_word: (oidx_q == 3'd7)};
						oidx_q      <= oidx_q + 1'b1;
						if (oidx_q == 3'd7) begin
							for (int i = 0; i < 8; i++) begin
								hash_q[i] <= H_INIT[i];
							end
							state_q <= B_LOAD;
						end
					end
				end
				default: state_q <= B_LOAD;
			endcase
		end
	end

endmodule

// ===== hw/rtl/sha256_stream_hasher.sv =====
// Top level of the SHA-256 byte stream hasher.
//
//  channel | valid     | ready     | word
//  --------+-----------+-----------+-------------------------------------------
//  in      | in_valid  | in_ready  | in_data: cmd, data_byte
//  out     | out_valid | out_ready | out_data: digest_word, word_index, last_word
//
// Absorb bytes are taken one per cycle while the four-entry word queue has room and no padding runs.
// Each 64-byte block takes 64 rounds, one per cycle while words are available, then the hash add.
// Finish pads the current block, then one or two blocks compress before 8 digest words.
// Reset empties the queue, clears counters and loads the initial hash values at once; no clearing pass.
// The packer stalls on a full queue; the engine stalls on an empty queue or out_ready low.
module sha256_stream_hasher import sha_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic    push;
	q_word_t push_word;
	logic    pop;
	q_word_t pop_word;
	q_stat_t q_stat;

	sha_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.push      (push),
		.push_word (push_word),
		.q_stat    (q_stat)
	);

	sha_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.pop_word  (pop_word),
		.stat      (q_stat)
	);

	sha_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_word    (pop_word),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !push || pop)
		else $error("word queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.empty |-> !pop)
		else $error("word queue underflow");

	a_finish_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.cmd == CMD_FINISH |=> !in_ready)
		else $error("input taken during padding");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.last_word |-> out_data.word_index == 3'd7)
		else $error("last word flag on wrong index");

endmodule
